// File: hdl/gei_pkg.sv
// Shared types, codes and constants for the GPIO edge interrupt controller.
`timescale 1ns / 1ps

package gei_pkg;

  localparam int unsigned PinCount = 16;
  localparam int unsigned PinIdxW  = (PinCount > 1) ? $clog2(PinCount) : 1;

  localparam logic [PinCount-1:0] PinsAllOnes  = '1;
  localparam logic [PinCount-1:0] PinsAllZeros = '0;

  // Bus access kind carried with each request
  typedef enum logic [1:0] {
    FuncNone  = 2'd0,
    FuncRead  = 2'd1,
    FuncWrite = 2'd2
  } func_e;

  // Register selector
  typedef enum logic [1:0] {
    RegMask   = 2'd0,
    RegStatus = 2'd1,
    RegPins   = 2'd2
  } reg_sel_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [1:0]          reg_select;
    logic [PinCount-1:0] write_data;
    logic [PinCount-1:0] pin_levels;
  } gei_req_t;

  typedef struct packed {
    logic [PinCount-1:0] read_data;
    logic [PinCount-1:0] pending_bits;
    logic                cascade_request;
    logic [PinIdxW-1:0]  lowest_pending;
  } gei_result_t;

endpackage

// File: hdl/gpio_edge_interrupt_controller.sv
// Top level of the GPIO edge interrupt controller: stream ports and pipeline registers.
//
//   Channel   Direction  Contents
//   s_axis    in         request: tuser = func, reg_select; tdata = write_data, pin_levels
//   m_axis    out        result: read_data, pending_bits, cascade_request, lowest_pending
//   cfg       in         edge_polarity write (write enable + data)
//
// One request per clock sustained while m_axis is ready; a result passes through the input register,
// then the result register, before it is offered on m_axis.
// The interrupt state updates as a request moves from the input register into
// the result register, so results appear in request order.
// A stall on m_axis holds the result register and backs up into the input register.
// Reset (rst_ni low, asynchronous) masks every pin, clears status, previous pins
// and edge_polarity, and empties both registers.
`timescale 1ns / 1ps

module gpio_edge_interrupt_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: edge_polarity
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] write_data, [31:16] pin_levels
  input  logic [3:0]  s_axis_tuser_i,   // [1:0] func, [3:2] reg_select
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [15:0] read_data, [31:16] pending_bits,
                                        // [32] cascade_request, [36:33] lowest_pending,
                                        // [39:37] zero
);

  localparam int unsigned ResW = 2 * gei_pkg::PinCount + 1 + gei_pkg::PinIdxW;

  logic [gei_pkg::PinCount-1:0] polarity_q;
  logic                         in_v_q;
  gei_pkg::gei_req_t            in_q;
  logic                         out_v_q;
  gei_pkg::gei_result_t         out_q;
  gei_pkg::gei_result_t         result;
  logic                         adv;
  logic                         s_fire;

  // Move a request forward when the result register is free or draining
  assign adv             = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Polarity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polarity_q <= gei_pkg::PinsAllZeros;
    end else if (cfg_we_i) begin
      polarity_q <= cfg_wdata_i;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.func       <= s_axis_tuser_i[1:0];
      in_q.reg_select <= s_axis_tuser_i[3:2];
      in_q.write_data <= s_axis_tdata_i[15:0];
      in_q.pin_levels <= s_axis_tdata_i[31:16];
    end
  end

  gei_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .req_i      (in_q),
    .polarity_i (polarity_q),
    .result_o   (result)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready_i) begin
      out_v_q <= in_v_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(40 - ResW)'(0), out_q.lowest_pending, out_q.cascade_request,
                            out_q.pending_bits, out_q.read_data};

endmodule

// File: hdl/gei_prio.sv
// Lowest-set-bit priority encoder over the pending pins.
`timescale 1ns / 1ps

module gei_prio (
  input  logic [gei_pkg::PinCount-1:0] pending_i,
  output logic                         any_o,
  output logic [gei_pkg::PinIdxW-1:0]  index_o
);

  // Scan from the top down so the lowest set bit wins; zero when none set
  always_comb begin
    index_o = '0;
    for (int i = gei_pkg::PinCount - 1; i >= 0; i--) begin
      if (pending_i[i]) begin
        index_o = gei_pkg::PinIdxW'(i);
      end
    end
  end

  assign any_o = |pending_i;

endmodule

// File: hdl/gei_core.sv
// Interrupt state, edge detection, register access and pending logic.
`timescale 1ns / 1ps

module gei_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  gei_pkg::gei_req_t            req_i,
  input  logic [gei_pkg::PinCount-1:0] polarity_i,
  output gei_pkg::gei_result_t         result_o
);

  logic [gei_pkg::PinCount-1:0] mask_q, mask_d;
  logic [gei_pkg::PinCount-1:0] status_q, status_d;
  logic [gei_pkg::PinCount-1:0] prev_q;
  logic [gei_pkg::PinCount-1:0] pins;
  logic [gei_pkg::PinCount-1:0] rising, falling, edges, asserted, pending;
  logic [gei_pkg::PinCount-1:0] rdata;
  logic                         is_read, is_write;
  logic                         any_pending;
  logic [gei_pkg::PinIdxW-1:0]  lowest;

  assign pins     = req_i.pin_levels;
  assign is_read  = (req_i.func == gei_pkg::FuncRead);
  assign is_write = (req_i.func == gei_pkg::FuncWrite);

  // Read mux: mask and status show their value before this request
  always_comb begin
    rdata = gei_pkg::PinsAllZeros;
    if (is_read) begin
      unique case (req_i.reg_select)
        gei_pkg::RegMask:   rdata = mask_q;
        gei_pkg::RegStatus: rdata = status_q;
        gei_pkg::RegPins:   rdata = pins;
        default:            rdata = gei_pkg::PinsAllZeros;
      endcase
    end
  end

  // Detect edges in each pin's trigger sense
  assign rising  = pins & ~prev_q;
  assign falling = prev_q & ~pins;
  assign edges   = (polarity_i & rising) | (~polarity_i & falling);

  // Apply writes; a fresh edge overrides a write-1-to-clear
  always_comb begin
    mask_d   = mask_q;
    status_d = status_q;
    if (is_write && req_i.reg_select == gei_pkg::RegMask) begin
      mask_d = req_i.write_data;
    end
    if (is_write && req_i.reg_select == gei_pkg::RegStatus) begin
      status_d = status_q & ~req_i.write_data;
    end
    status_d = status_d | edges;
  end

  // Level asserted: high for rising pins, low for falling pins
  assign asserted = (polarity_i & pins) | ~(polarity_i | pins);
  assign pending  = ~mask_d & (status_d | asserted);

  gei_prio u_prio (
    .pending_i (pending),
    .any_o     (any_pending),
    .index_o   (lowest)
  );

  assign result_o.read_data       = rdata;
  assign result_o.pending_bits    = pending;
  assign result_o.cascade_request = any_pending;
  assign result_o.lowest_pending  = lowest;

  // Advance state when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= gei_pkg::PinsAllOnes;
      status_q <= gei_pkg::PinsAllZeros;
      prev_q   <= gei_pkg::PinsAllZeros;
    end else if (adv_i) begin
      mask_q   <= mask_d;
      status_q <= status_d;
      prev_q   <= pins;
    end
  end

  // An edge of an advancing request always ends up latched in status
  a_edge_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> ((status_q & $past(edges)) == $past(edges)))
    else $error("edge not latched in status");

  // A mask write takes effect for the next request
  a_mask_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && is_write && req_i.reg_select == gei_pkg::RegMask)
      |=> (mask_q == $past(req_i.write_data)))
    else $error("mask write lost");

  // Previous pins track the last processed request
  a_prev_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (prev_q == $past(pins)))
    else $error("previous pins not updated");

  // State holds while no request advances
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(mask_q) && $stable(status_q) && $stable(prev_q)))
    else $error("state changed without a request");

endmodule

// File: tb/gei_irq_monitor.sv
// Stream monitor for the GPIO edge interrupt controller: predicts every result and compares it.
`timescale 1ns / 1ps

module gei_irq_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] write_data, [31:16] pin_levels
  input  logic [3:0]  s_axis_tuser_i,   // [1:0] func, [3:2] reg_select
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // [15:0] read_data, [31:16] pending_bits,
                                        // [32] cascade_request, [36:33] lowest_pending
  output int          error_count_o,
  output int          open_results_o,
  output int          results_seen_o
);

  // Shadow copy of the interrupt state
  logic [gei_pkg::PinCount-1:0] polarity_q;
  logic [gei_pkg::PinCount-1:0] mask_q;
  logic [gei_pkg::PinCount-1:0] status_q;
  logic [gei_pkg::PinCount-1:0] prev_pins_q;

  // Responses owed by the block, oldest first
  gei_pkg::gei_result_t irq_response_q[$];

  // Apply one request to the shadow state and return the response it earns
  function automatic gei_pkg::gei_result_t advance_irq_state(gei_pkg::gei_req_t req);
    logic [gei_pkg::PinCount-1:0] edges;
    logic [gei_pkg::PinCount-1:0] asserted;
    logic [gei_pkg::PinCount-1:0] pending;
    gei_pkg::gei_result_t         res;
    res = '0;

    // Mask and status read the value held before this request
    if (req.func == gei_pkg::FuncRead) begin
      case (req.reg_select)
        gei_pkg::RegMask:   res.read_data = mask_q;
        gei_pkg::RegStatus: res.read_data = status_q;
        gei_pkg::RegPins:   res.read_data = req.pin_levels;
        default:            res.read_data = '0;
      endcase
    end

    edges = (polarity_q & req.pin_levels & ~prev_pins_q)
          | (~polarity_q & prev_pins_q & ~req.pin_levels);

    if (req.func == gei_pkg::FuncWrite && req.reg_select == gei_pkg::RegMask) begin
      mask_q = req.write_data;
    end
    if (req.func == gei_pkg::FuncWrite && req.reg_select == gei_pkg::RegStatus) begin
      status_q = status_q & ~req.write_data;
    end
    // A fresh edge wins over a clear of the same bit
    status_q    = status_q | edges;
    prev_pins_q = req.pin_levels;

    asserted = (polarity_q & req.pin_levels) | ~(polarity_q | req.pin_levels);
    pending  = ~mask_q & (status_q | asserted);

    res.pending_bits    = pending;
    res.cascade_request = |pending;
    res.lowest_pending  = '0;
    for (int i = gei_pkg::PinCount - 1; i >= 0; i--) begin
      if (pending[i]) res.lowest_pending = gei_pkg::PinIdxW'(i);
    end
    return res;
  endfunction

  // Track config, queue predictions, check results in order
  always @(posedge clk_i or negedge rst_ni) begin
    gei_pkg::gei_req_t    req;
    gei_pkg::gei_result_t got;
    gei_pkg::gei_result_t want;
    int                   bad;
    if (!rst_ni) begin
      polarity_q     = gei_pkg::PinsAllZeros;
      mask_q         = gei_pkg::PinsAllOnes;
      status_q       = gei_pkg::PinsAllZeros;
      prev_pins_q    = gei_pkg::PinsAllZeros;
      irq_response_q.delete();
      error_count_o  <= 0;
      open_results_o <= 0;
      results_seen_o <= 0;
    end else begin
      bad = 0;
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.read_data       = m_axis_tdata_i[15:0];
        got.pending_bits    = m_axis_tdata_i[31:16];
        got.cascade_request = m_axis_tdata_i[32];
        got.lowest_pending  = m_axis_tdata_i[36:33];
        results_seen_o <= results_seen_o + 1;
        if (irq_response_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata_i);
          bad++;
        end else begin
          want = irq_response_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            bad++;
          end
          if (got.pending_bits !== want.pending_bits) begin
            $error("pending_bits: expected %h, got %h", want.pending_bits, got.pending_bits);
            bad++;
          end
          if (got.cascade_request !== want.cascade_request) begin
            $error("cascade_request: expected %b, got %b",
                   want.cascade_request, got.cascade_request);
            bad++;
          end
          if (got.lowest_pending !== want.lowest_pending) begin
            $error("lowest_pending: expected %0d, got %0d",
                   want.lowest_pending, got.lowest_pending);
            bad++;
          end
        end
      end

      if (cfg_we_i) polarity_q = cfg_wdata_i;

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        req.func       = s_axis_tuser_i[1:0];
        req.reg_select = s_axis_tuser_i[3:2];
        req.write_data = s_axis_tdata_i[15:0];
        req.pin_levels = s_axis_tdata_i[31:16];
        irq_response_q.push_back(advance_irq_state(req));
      end

      error_count_o  <= error_count_o + bad;
      open_results_o <= irq_response_q.size();
    end
  end

endmodule

// File: tb/tb_gpio_edge_interrupt_controller.sv
// Testbench top for the GPIO edge interrupt controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_gpio_edge_interrupt_controller;

  localparam int ClockLimit = 200000;
  localparam int ChunkSize  = 110;

  // Codes outside the defined set, still legal on the bus
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [1:0] RegUnused  = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [15:0] cfg_wdata     = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;   // [15:0] write_data, [31:16] pin_levels
  logic [3:0]  s_axis_tuser  = '0;   // [1:0] func, [3:2] reg_select
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;

  int          send_idle_pct   = 12;
  int          recv_idle_pct   = 63;
  logic [15:0] pins_now        = '0;
  int          requests_sent   = 0;
  int          polarity_writes = 0;
  int          cycle_count;
  int          error_count;
  int          open_results;
  int          results_seen;

  always #5 clk_i = ~clk_i;

  gpio_edge_interrupt_controller uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  gei_irq_monitor monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .error_count_o   (error_count),
    .open_results_o  (open_results),
    .results_seen_o  (results_seen)
  );

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort a hung run
  initial begin
    for (cycle_count = 0; cycle_count < ClockLimit; cycle_count++) @(posedge clk_i);
    $display("[gpio_edge_interrupt_controller] ERROR");
    $finish;
  end

  // Offer one request, with random idle cycles first, and hold until accepted
  task automatic send_request(input logic [1:0] func, input logic [1:0] sel,
                              input logic [15:0] wdata, input logic [15:0] pins);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  <= {sel, func};
    s_axis_tdata  <= {pins, wdata};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pins_now = pins;
    requests_sent++;
  endtask

  // Stop sending and wait for every owed result
  task automatic drain_requests();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (open_results != 0) @(negedge clk_i);
  endtask

  // Write edge_polarity while the block is idle
  task automatic write_polarity(input logic [15:0] value);
    drain_requests();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    polarity_writes++;
  endtask

  initial begin
    logic [1:0]  func;
    logic [1:0]  sel;
    logic [15:0] wdata;
    logic [15:0] pins;
    logic [15:0] polarity_plan [5];
    int          pick;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all falling sense after reset, everything masked
    send_request(gei_pkg::FuncRead,  gei_pkg::RegMask,   16'h0000, 16'h0000);
    send_request(gei_pkg::FuncRead,  gei_pkg::RegStatus, 16'hffff, 16'hffff);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegMask,   16'h0000, 16'hffff);
    // all pins fall: every status bit latches
    send_request(gei_pkg::FuncRead,  gei_pkg::RegPins,   16'h0000, 16'h0000);
    send_request(gei_pkg::FuncRead,  gei_pkg::RegStatus, 16'h0000, 16'h0000);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegStatus, 16'hffff, 16'hffff);
    // clear lands with a new falling edge: the edge wins
    send_request(gei_pkg::FuncWrite, gei_pkg::RegStatus, 16'hffff, 16'h0000);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegStatus, 16'h00ff, 16'h0000);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegPins,   16'h1234, 16'h8000);
    send_request(FuncUnused,         gei_pkg::RegMask,   16'h0000, 16'h8000);
    send_request(gei_pkg::FuncRead,  RegUnused,          16'hffff, 16'h0001);
    send_request(gei_pkg::FuncWrite, RegUnused,          16'hffff, 16'h0001);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegMask,   16'h7fff, 16'hffff);
    send_request(gei_pkg::FuncRead,  gei_pkg::RegMask,   16'h0000, 16'h7fff);

    // Directed: rising sense on every pin
    write_polarity(16'hffff);
    send_request(gei_pkg::FuncNone,  gei_pkg::RegMask,   16'h0000, 16'h0000);
    send_request(gei_pkg::FuncRead,  gei_pkg::RegStatus, 16'h0000, 16'hffff);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegMask,   16'h0000, 16'hffff);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegStatus, 16'hffff, 16'hffff);
    send_request(gei_pkg::FuncRead,  gei_pkg::RegStatus, 16'h0000, 16'h0000);
    send_request(gei_pkg::FuncWrite, gei_pkg::RegStatus, 16'hffff, 16'h8000);
    write_polarity(16'h0000);
    send_request(gei_pkg::FuncRead,  gei_pkg::RegStatus, 16'h0000, 16'h0000);

    // Random: three stall profiles, polarity changed between chunks
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      polarity_plan[0] = 16'h0000;
      polarity_plan[1] = 16'hffff;
      polarity_plan[2] = 16'h5555;
      polarity_plan[3] = 16'haaaa;
      polarity_plan[4] = 16'($urandom);
      for (int chunk = 0; chunk < 5; chunk++) begin
        write_polarity(polarity_plan[chunk]);
        for (int n = 0; n < ChunkSize; n++) begin
          pick = $urandom_range(0, 99);
          if (pick < 35)      func = gei_pkg::FuncNone;
          else if (pick < 65) func = gei_pkg::FuncRead;
          else if (pick < 95) func = gei_pkg::FuncWrite;
          else                func = FuncUnused;

          pick = $urandom_range(0, 9);
          if (pick < 4)      sel = gei_pkg::RegMask;
          else if (pick < 7) sel = gei_pkg::RegStatus;
          else if (pick < 9) sel = gei_pkg::RegPins;
          else               sel = RegUnused;

          case ($urandom_range(0, 7))
            0:       wdata = 16'h0000;
            1:       wdata = 16'hffff;
            2:       wdata = 16'($urandom & $urandom);
            3:       wdata = 16'($urandom | $urandom);
            default: wdata = 16'($urandom);
          endcase

          // Mostly a few pins toggle, sometimes a jump
          case ($urandom_range(0, 9))
            0:       pins = 16'h0000;
            1:       pins = 16'hffff;
            2:       pins = 16'($urandom);
            3:       pins = pins_now ^ 16'($urandom & $urandom & $urandom);
            default: pins = pins_now ^ (16'h0001 << $urandom_range(0, 15));
          endcase

          send_request(func, sel, wdata, pins);
        end
      end
    end

    drain_requests();
    repeat (8) @(negedge clk_i);

    $display("Ran %0d requests under three stall profiles and %0d polarity settings",
             requests_sent, polarity_writes);
    $display("Compared %0d results, %0d field mismatches", results_seen, error_count);
    if (error_count == 0 && open_results == 0) begin
      $display("[gpio_edge_interrupt_controller] OK");
    end else begin
      $display("[gpio_edge_interrupt_controller] ERROR");
    end
    $finish;
  end

endmodule
